// ===== design/positional_list_store_core_assert.svh =====
// Assertion macros for the verification files of the positional list store (used by plst_checker).
// No dependencies; the including module must provide aclk and aresetn.
`ifndef POSITIONAL_LIST_STORE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_CORE_ASSERT_SVH

// Checked only while out of reset.
`define PLST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PLST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/plst_pkg.sv =====
// Shared types, field widths and codes for the positional list store.
// No dependencies.
package plst_pkg;

    localparam int DEPTH = 16;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int ST_W    = 2;
    localparam int CNTF_W  = 5;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_REM_LAST = 3'd2,
        OP_REM_AT   = 3'd3,
        OP_READ     = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic [CNTF_W-1:0]       entry_count;
        logic signed [VAL_W-1:0] read_value;
    } out_item_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [CMP_W-1:0]        pos;
        logic [CMP_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        status_t                 status;
        logic [CNT_W-1:0]        count_next;
        logic                    do_read;
    } ctrl_res_t;

endpackage

// ===== design/positional_list_store_core.sv =====
// Top level of the positional list store: handshake, count register, result
// register and the cell chain. Depends on plst_pkg, plst_ctrl and plst_cell.
//
// Usage:
//   s_valid/s_ready/s_data carry one operation per item: append, insert at a
//   position, remove last, remove at a position, or read at a position.
//   m_valid/m_ready/m_data return exactly one result item per operation with
//   status, entry count after the operation and the value read.
//   An item is executed in the cycle it is accepted: the cells of the chain that
//   the operation covers shift or load at that edge, so the result is on m_data in the next cycle.
//   Throughput is one item per cycle; the single result register sets this,
//   since a new item is taken whenever that register is empty or being drained
//   in the same cycle.
//   When the receiver holds m_ready low the result waits and s_ready drops
//   until it is taken; no item is lost.
//   Reset clears the count and the result valid; stored entries are not
//   cleared, but an entry is only ever read below the count, where it has been
//   written.
module positional_list_store_core
    import plst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    out_item_t               res_reg;
    out_item_t               res_next;
    logic                    go;
    cell_cmd_t               cmd;
    ctrl_res_t               ctl;
    logic signed [VAL_W-1:0] cell_data [DEPTH];
    logic [CMP_W-1:0]        pos_e;
    logic [CMP_W-1:0]        cnt_e;

    assign s_ready = !m_valid_reg || m_ready;
    assign go      = s_valid && s_ready;

    plst_ctrl u_ctrl (
        .go    (go),
        .item  (s_data),
        .count (count_reg),
        .cmd   (cmd),
        .res   (ctl)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_d;
        logic signed [VAL_W-1:0] right_d;

        if (i == 0) begin : g_head
            assign left_d = '0;
        end else begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_body
            assign right_d = cell_data[i+1];
        end

        plst_cell u_cell (
            .aclk       (aclk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    assign pos_e = CMP_W'(s_data.position);
    assign cnt_e = CMP_W'(ctl.count_next);

    always_comb begin
        res_next             = res_reg;
        m_valid_next         = m_valid_reg;
        count_next           = count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (go) begin
            count_next           = ctl.count_next;
            m_valid_next         = 1'b1;
            res_next.status      = ctl.status;
            res_next.entry_count = cnt_e[CNTF_W-1:0];
            res_next.read_value  = ctl.do_read ? cell_data[pos_e[IDX_W-1:0]] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

endmodule

// ===== design/plst_cell.sv =====
// One storage cell of the list chain: holds a single entry and can load a new
// value or take its left or right neighbor's entry. Depends on plst_pkg.
module plst_cell
    import plst_pkg::*;
(
    input  logic                    aclk,
    input  logic [IDX_W-1:0]        idx,
    input  cell_cmd_t               cmd,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    output logic signed [VAL_W-1:0] data
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic [CMP_W-1:0]        idx_e;
    logic [CMP_W-1:0]        idx_inc;

    assign idx_e   = CMP_W'(idx);
    assign idx_inc = idx_e + CMP_W'(1);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (idx_e == cmd.pos) begin
                data_next = cmd.value;
            end else if (idx_e > cmd.pos && idx_e <= cmd.count) begin
                data_next = left_data;
            end
        end else if (cmd.del) begin
            // Entries above the removed one each move down one place.
            if (idx_e >= cmd.pos && idx_inc < cmd.count) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/plst_ctrl.sv =====
// Operation decode for the list store: status, next count and the command
// broadcast to the cell chain. Depends on plst_pkg.
module plst_ctrl
    import plst_pkg::*;
(
    input  logic             go,
    input  in_item_t         item,
    input  logic [CNT_W-1:0] count,
    output cell_cmd_t        cmd,
    output ctrl_res_t        res
);

    logic [CMP_W-1:0] count_e;
    logic [CMP_W-1:0] pos_e;
    logic             full;
    logic             empty;
    logic             ins;
    logic             del;

    assign count_e = CMP_W'(count);
    assign pos_e   = CMP_W'(item.position);
    assign full    = count_e >= CMP_W'(DEPTH);
    assign empty   = count_e == '0;

    always_comb begin
        res.status     = ST_OK;
        res.count_next = count;
        res.do_read    = 1'b0;
        ins            = 1'b0;
        del            = 1'b0;
        cmd.pos        = pos_e;
        unique case (item.operation)
            OP_APPEND: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    // Append is an insert at the tail.
                    ins            = 1'b1;
                    cmd.pos        = count_e;
                    res.count_next = count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    res.status = ST_FULL;
                end else if (pos_e > count_e) begin
                    res.status = ST_BADPOS;
                end else begin
                    ins            = 1'b1;
                    res.count_next = count + CNT_W'(1);
                end
            end
            OP_REM_LAST: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.count_next = count - CNT_W'(1);
                end
            end
            OP_REM_AT: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else if (pos_e >= count_e) begin
                    res.status = ST_BADPOS;
                end else begin
                    del            = 1'b1;
                    res.count_next = count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (empty) begin
                    res.status = ST_EMPTY;
                end else if (pos_e >= count_e) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.do_read = 1'b1;
                end
            end
            default: begin
                res.status = ST_BADPOS;
            end
        endcase
        cmd.ins   = ins & go;
        cmd.del   = del & go;
        cmd.count = count_e;
        cmd.value = item.value;
    end

endmodule

// ===== design/plst_checker.sv =====
// Port-level checks for the positional list store, bound to the top level.
// Depends on plst_pkg and positional_list_store_core_assert.svh.
`include "positional_list_store_core_assert.svh"

module plst_checker
    import plst_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A waiting result item holds until the receiver takes it.
    `PLST_ASSERT(a_res_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result item dropped or changed while stalled")

    // A failed operation returns a zero value.
    `PLST_ASSERT(a_rd_zero, m_valid && m_data.status != ST_OK |-> m_data.read_value == '0, "failed operation returned a value")

    // An empty result register always takes a new item.
    `PLST_ASSERT(a_ready_empty, !m_valid |-> s_ready, "input stalled with no result pending")

    // Reset empties the result register.
    `PLST_ASSERT_ALWAYS(a_rst_clear, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind positional_list_store_core plst_checker u_plst_checker (.*);

// ===== test/positional_list_store_core_tb.sv =====
// Self-checking testbench for positional_list_store_core: random and directed list operations
// against a predicting scoreboard, with bursty sender and stalling receiver.
// Depends on plst_pkg and the positional_list_store_core RTL.
module positional_list_store_core_tb;
    import plst_pkg::*;

    // Operation codes the block does not define; they must report a bad position.
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam int RANDOM_ITEMS = 1650;
    localparam int TAIL_CYCLES  = 8;
    localparam int RUN_LIMIT    = 8_000_000;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    localparam int RX_OPEN   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_MOSTLY = 2;
    localparam int RX_CHOKED = 3;

    class list_scoreboard;
        logic signed [VAL_W-1:0] slots [DEPTH];
        int unsigned             used;
        out_item_t               due_q [$];
        int unsigned             mismatches;

        function new();
            used       = 0;
            mismatches = 0;
        endfunction

        // Applies one accepted item to the shadow list and queues its result.
        function void note_item(in_item_t it);
            out_item_t   res;
            int unsigned p;
            int unsigned k;
            res.status     = ST_OK;
            res.read_value = '0;
            p = 32'(it.position);
            case (it.operation)
                OP_APPEND: begin
                    if (used >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        slots[used] = it.value;
                        used++;
                    end
                end
                OP_INSERT: begin
                    if (used >= DEPTH) begin
                        res.status = ST_FULL;
                    end else if (p > used) begin
                        res.status = ST_BADPOS;
                    end else begin
                        for (k = used; k > p; k--) slots[k] = slots[k-1];
                        slots[p] = it.value;
                        used++;
                    end
                end
                OP_REM_LAST: begin
                    if (used == 0) res.status = ST_EMPTY;
                    else used--;
                end
                OP_REM_AT: begin
                    if (used == 0) begin
                        res.status = ST_EMPTY;
                    end else if (p >= used) begin
                        res.status = ST_BADPOS;
                    end else begin
                        for (k = p; k + 1 < used; k++) slots[k] = slots[k+1];
                        used--;
                    end
                end
                OP_READ: begin
                    if (used == 0) res.status = ST_EMPTY;
                    else if (p >= used) res.status = ST_BADPOS;
                    else res.read_value = slots[p];
                end
                default: res.status = ST_BADPOS;
            endcase
            res.entry_count = CNTF_W'(used);
            due_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected result item, status %0d count %0d value %0d",
                         $time, got.status, got.entry_count, got.read_value);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count mismatch, expected %0d, got %0d",
                         $time, want.entry_count, got.entry_count);
                mismatches++;
            end
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value mismatch, expected %0d, got %0d",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    list_scoreboard sb = new();

    int burst_left = 0;
    int rx_mode    = RX_OPEN;
    int rx_left    = 0;

    positional_list_store_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Receiver: switches between open, random and heavily choked stretches.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= int'($urandom_range(RX_OPEN, RX_CHOKED));
            rx_left <= int'($urandom_range(20, 200));
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
            default:   m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_item(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    function automatic in_item_t make_item(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                                           logic [POS_W-1:0] pos);
        in_item_t it;
        it.operation = op;
        it.value     = val;
        it.position  = pos;
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions near the live range, sometimes anywhere in the field.
    function automatic logic [POS_W-1:0] pick_position(int unsigned used);
        if ($urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return POS_W'($urandom_range(0, used));
    endfunction

    function automatic logic [OP_W-1:0] pick_operation(int mode);
        int r;
        r = int'($urandom_range(0, 99));
        if (r >= 98) begin
            case ($urandom_range(0, 2))
                0:       return OP_RSVD_5;
                1:       return OP_RSVD_6;
                default: return OP_RSVD_7;
            endcase
        end
        case (mode)
            MODE_FILL: begin
                if (r < 45) return OP_APPEND;
                if (r < 85) return OP_INSERT;
                if (r < 92) return OP_READ;
                if (r < 95) return OP_REM_LAST;
                return OP_REM_AT;
            end
            MODE_DRAIN: begin
                if (r < 10) return OP_APPEND;
                if (r < 20) return OP_INSERT;
                if (r < 45) return OP_REM_LAST;
                if (r < 75) return OP_REM_AT;
                return OP_READ;
            end
            default: begin
                if (r < 22) return OP_APPEND;
                if (r < 44) return OP_INSERT;
                if (r < 56) return OP_REM_LAST;
                if (r < 70) return OP_REM_AT;
                return OP_READ;
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_item(in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Ends the current burst with a random gap, or lets the burst continue.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 150))
                                                     : int'($urandom_range(1, 12));
        end
    endtask

    // Holds the sender off until every queued result has been returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        @(posedge aclk);
    endtask

    initial begin
        in_item_t directed [$];
        in_item_t it;
        int       mode;
        int       run_left;
        int       sent;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty list, bad insert position, head insert on empty, value extremes.
        directed.push_back(make_item(OP_READ, '0, 5'd0));
        directed.push_back(make_item(OP_REM_LAST, '0, 5'd0));
        directed.push_back(make_item(OP_REM_AT, '0, 5'd0));
        directed.push_back(make_item(OP_INSERT, 32'sd7, 5'd1));
        directed.push_back(make_item(OP_INSERT, VAL_MIN, 5'd0));
        directed.push_back(make_item(OP_APPEND, VAL_MAX, 5'd0));
        directed.push_back(make_item(OP_APPEND, '0, 5'd31));
        directed.push_back(make_item(OP_APPEND, -32'sd1, 5'd0));
        directed.push_back(make_item(OP_INSERT, 32'sh5a5a_5a5a, 5'd0));
        directed.push_back(make_item(OP_INSERT, 32'sh1234_5678, 5'd5));
        directed.push_back(make_item(OP_INSERT, 32'sd9, 5'd7));
        directed.push_back(make_item(OP_INSERT, -32'sd2, 5'd3));
        directed.push_back(make_item(OP_READ, '0, 5'd0));
        directed.push_back(make_item(OP_READ, '0, 5'd6));
        directed.push_back(make_item(OP_READ, '0, 5'd7));
        directed.push_back(make_item(OP_READ, '0, 5'd31));
        directed.push_back(make_item(OP_REM_AT, '0, 5'd0));
        directed.push_back(make_item(OP_REM_AT, '0, 5'd6));
        directed.push_back(make_item(OP_REM_AT, '0, 5'd31));
        directed.push_back(make_item(OP_REM_AT, '0, 5'd5));
        directed.push_back(make_item(OP_REM_LAST, '0, 5'd0));
        directed.push_back(make_item(OP_RSVD_5, -32'sd1, 5'd31));
        directed.push_back(make_item(OP_RSVD_6, VAL_MAX, 5'd0));
        directed.push_back(make_item(OP_RSVD_7, VAL_MIN, 5'd16));
        directed.push_back(make_item(OP_READ, '0, 5'd3));

        foreach (directed[i]) begin
            send_item(directed[i]);
            pace_sender();
        end
        drain_results();

        // Random part: runs biased toward filling, draining or a mix, so the list
        // regularly reaches both full and empty.
        sent     = 0;
        run_left = 0;
        mode     = MODE_MIXED;
        while (sent < RANDOM_ITEMS) begin
            if (run_left == 0) begin
                mode     = int'($urandom_range(MODE_FILL, MODE_MIXED));
                run_left = int'($urandom_range(8, 48));
            end
            run_left--;
            it.operation = pick_operation(mode);
            it.value     = pick_value();
            it.position  = pick_position(sb.used);
            send_item(it);
            sent++;
            if (sent == RANDOM_ITEMS / 2) drain_results();
            else pace_sender();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
